@@ src/zsal_pkg.sv @@
// Shared types and constants for the zero-sentinel array list.
`default_nettype none

package zsal_pkg;

  localparam int unsigned IdxW  = 8;
  localparam int unsigned DataW = 32;

  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_SET    = 2'd1,
    OP_INSERT = 2'd2,
    OP_REMOVE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_ZERO  = 2'd3
  } status_e;

  typedef struct packed {
    op_e                     op;
    logic [IdxW-1:0]         index;
    logic signed [DataW-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [DataW-1:0] data;
    status_e                 status;
  } resp_t;

  // pointer update
  typedef enum logic [1:0] {
    PTR_HOLD,
    PTR_INC,
    PTR_DEC,
    PTR_IDX1
  } ptr_op_e;

  // read address source
  typedef enum logic [1:0] {
    RD_IN,
    RD_NEXT,
    RD_BELOW
  } rd_sel_e;

  typedef enum logic [1:0] {
    WA_PTR,
    WA_PTRM1,
    WA_IDX
  } wa_sel_e;

  typedef enum logic [1:0] {
    WD_ZERO,
    WD_VAL,
    WD_RDATA
  } wd_sel_e;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_CUR,
    RES_HELD
  } res_sel_e;

  typedef struct packed {
    logic     load_req;
    logic     cap_cur;
    ptr_op_e  ptr_op;
    rd_sel_e  rd_sel;
    logic     wr_en;
    wa_sel_e  wa_sel;
    wd_sel_e  wd_sel;
    logic     res_load;
    res_sel_e res_sel;
    status_e  res_status;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic val_zero;
    logic in_store;
    logic cur_zero;
    logic rd_zero;
    logic ptr_end;
    logic ptr_last;
    logic ptr_at_idx;
  } sts_t;

endpackage

`default_nettype wire

@@ src/zero_sentinel_array_list.sv @@
// Top level of the zero-sentinel array list: slot store with shifting insert/remove.
//
// Input channel (in_valid_i/in_ready_o/in_req_i) carries one request word:
// op (read, overwrite, insert, remove), slot index and value. Output channel
// (out_valid_o/out_ready_i/out_resp_o) returns one response word per request:
// data read or removed, and a status code.
// After reset the slot RAM is cleared to zero, one slot a cycle, and
// in_ready_o stays low until the clear pass has written every slot.
// Requests are served one at a time. A read, overwrite, rejected request or
// insert into an empty slot goes from acceptance through a lookup state and
// a hand-off state that loads the output register, then the next request is
// taken. Insert into an occupied slot adds a search and a shift over the run
// of occupied slots from the index up to the first empty slot, one RAM access
// each per cycle. Remove walks the run once.
// The slot RAM has a single read port.
// The response sits in an output register while the next request is taken;
// if the receiver stalls, a finished response waits in a holding register
// and no further request is accepted until the output register frees.
`default_nettype none

module zero_sentinel_array_list import zsal_pkg::*; #(
  parameter int unsigned DEPTH = 256
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire req_t  in_req_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output resp_t      out_resp_o
);

  cmd_t cmd;
  sts_t sts;

  zsal_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  zsal_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (in_req_i),
    .resp_o (out_resp_o),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

endmodule

`default_nettype wire

@@ src/zsal_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module zsal_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ src/zsal_dp.sv @@
// Datapath: request registers, slot pointer, slot RAM and result registers.
`default_nettype none

module zsal_dp import zsal_pkg::*; #(
  parameter int unsigned DEPTH = 256
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire req_t req_i,
  output resp_t     resp_o,
  input  wire cmd_t cmd_i,
  output sts_t      sts_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned PW = AW + 1;
  localparam logic [PW-1:0] PtrEnd  = PW'(DEPTH);
  localparam logic [PW-1:0] PtrLast = PW'(DEPTH - 1);

  op_e                     op_q;
  logic [PW-1:0]           idx_q;
  logic                    inside_q;
  logic signed [DataW-1:0] val_q;
  logic signed [DataW-1:0] cur_q;
  logic [PW-1:0]           ptr_q, ptr_d;
  logic [PW-1:0]           ptr_m1, ptr_below;
  logic signed [DataW-1:0] res_data_q;
  status_e                 res_status_q;
  logic signed [DataW-1:0] out_data_q;
  status_e                 out_status_q;

  logic [AW-1:0]    raddr, waddr;
  logic [DataW-1:0] wdata, rdata;
  logic [DataW-1:0] cur;

  assign ptr_m1 = ptr_q - PW'(1);

  always_comb begin
    case (cmd_i.ptr_op)
      PTR_HOLD: ptr_d = ptr_q;
      PTR_INC:  ptr_d = ptr_q + PW'(1);
      PTR_DEC:  ptr_d = ptr_m1;
      PTR_IDX1: ptr_d = idx_q + PW'(1);
      default:  ptr_d = ptr_q;
    endcase
  end

  assign ptr_below = ptr_d - PW'(1);

  always_comb begin
    case (cmd_i.rd_sel)
      RD_IN:    raddr = AW'(req_i.index);
      RD_NEXT:  raddr = ptr_d[AW-1:0];
      RD_BELOW: raddr = ptr_below[AW-1:0];
      default:  raddr = ptr_d[AW-1:0];
    endcase
  end

  always_comb begin
    case (cmd_i.wa_sel)
      WA_PTR:   waddr = ptr_q[AW-1:0];
      WA_PTRM1: waddr = ptr_m1[AW-1:0];
      WA_IDX:   waddr = idx_q[AW-1:0];
      default:  waddr = ptr_q[AW-1:0];
    endcase
  end

  always_comb begin
    case (cmd_i.wd_sel)
      WD_ZERO:  wdata = '0;
      WD_VAL:   wdata = val_q;
      WD_RDATA: wdata = rdata;
      default:  wdata = '0;
    endcase
  end

  zsal_ram #(
    .WIDTH (DataW),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // a slot past the end always reads as empty
  assign cur = inside_q ? rdata : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else begin
      ptr_q <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      op_q     <= req_i.op;
      idx_q    <= PW'(req_i.index);
      inside_q <= 32'(req_i.index) < DEPTH;
      val_q    <= req_i.value;
    end
    if (cmd_i.cap_cur) begin
      cur_q <= cur;
    end
    if (cmd_i.res_load) begin
      case (cmd_i.res_sel)
        RES_ZERO: res_data_q <= '0;
        RES_CUR:  res_data_q <= cur;
        RES_HELD: res_data_q <= cur_q;
        default:  res_data_q <= '0;
      endcase
      res_status_q <= cmd_i.res_status;
    end
    if (cmd_i.out_load) begin
      out_data_q   <= res_data_q;
      out_status_q <= res_status_q;
    end
  end

  assign resp_o = '{data: out_data_q, status: out_status_q};

  assign sts_o = '{
    op:         op_q,
    val_zero:   val_q == '0,
    in_store:   inside_q,
    cur_zero:   cur == '0,
    rd_zero:    rdata == '0,
    ptr_end:    ptr_q == PtrEnd,
    ptr_last:   ptr_q == PtrLast,
    ptr_at_idx: ptr_q == idx_q
  };

endmodule

`default_nettype wire

@@ src/zsal_ctrl.sv @@
// Controller: sequences clear pass, lookup, search, shifts and result hand-off.
`default_nettype none

module zsal_ctrl import zsal_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output cmd_t      cmd_o,
  input  wire sts_t sts_i
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_SEARCH,
    S_SHIFT,
    S_REMOVE,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '{
      load_req:   1'b0,
      cap_cur:    1'b0,
      ptr_op:     PTR_HOLD,
      rd_sel:     RD_NEXT,
      wr_en:      1'b0,
      wa_sel:     WA_PTR,
      wd_sel:     WD_ZERO,
      res_load:   1'b0,
      res_sel:    RES_ZERO,
      res_status: ST_OK,
      out_load:   1'b0
    };

    case (state_q)
      S_CLEAR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.ptr_op = PTR_INC;
        if (sts_i.ptr_last) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        cmd_o.rd_sel = RD_IN;
        if (accept) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_LOOK;
        end
      end

      S_LOOK: begin
        cmd_o.cap_cur  = 1'b1;
        cmd_o.res_load = 1'b1;
        state_d        = S_DONE;
        case (sts_i.op)
          OP_READ: begin
            cmd_o.res_sel    = RES_CUR;
            cmd_o.res_status = sts_i.cur_zero ? ST_EMPTY : ST_OK;
          end
          OP_SET: begin
            if (sts_i.val_zero) begin
              cmd_o.res_status = ST_ZERO;
            end else if (sts_i.cur_zero) begin
              cmd_o.res_status = ST_EMPTY;
            end else begin
              cmd_o.wr_en  = 1'b1;
              cmd_o.wa_sel = WA_IDX;
              cmd_o.wd_sel = WD_VAL;
            end
          end
          OP_INSERT: begin
            if (sts_i.val_zero) begin
              cmd_o.res_status = ST_ZERO;
            end else if (!sts_i.in_store) begin
              cmd_o.res_status = ST_FULL;
            end else if (sts_i.cur_zero) begin
              cmd_o.wr_en  = 1'b1;
              cmd_o.wa_sel = WA_IDX;
              cmd_o.wd_sel = WD_VAL;
            end else begin
              cmd_o.res_load = 1'b0;
              cmd_o.ptr_op   = PTR_IDX1;
              state_d        = S_SEARCH;
            end
          end
          OP_REMOVE: begin
            if (sts_i.cur_zero) begin
              cmd_o.res_status = ST_EMPTY;
            end else begin
              cmd_o.res_load = 1'b0;
              cmd_o.ptr_op   = PTR_IDX1;
              state_d        = S_REMOVE;
            end
          end
          default: ;
        endcase
      end

      // ptr names the slot whose word sits on the read port
      S_SEARCH: begin
        if (sts_i.ptr_end) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_FULL;
          state_d          = S_DONE;
        end else if (sts_i.rd_zero) begin
          cmd_o.rd_sel = RD_BELOW;
          state_d      = S_SHIFT;
        end else begin
          cmd_o.ptr_op = PTR_INC;
        end
      end

      // move slot ptr-1 up into ptr, walking down to the index
      S_SHIFT: begin
        cmd_o.wr_en = 1'b1;
        if (sts_i.ptr_at_idx) begin
          cmd_o.wa_sel   = WA_IDX;
          cmd_o.wd_sel   = WD_VAL;
          cmd_o.res_load = 1'b1;
          state_d        = S_DONE;
        end else begin
          cmd_o.wa_sel = WA_PTR;
          cmd_o.wd_sel = WD_RDATA;
          cmd_o.ptr_op = PTR_DEC;
          cmd_o.rd_sel = RD_BELOW;
        end
      end

      // move slot ptr down into ptr-1 until an empty word is moved
      S_REMOVE: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wa_sel  = WA_PTRM1;
        cmd_o.res_sel = RES_HELD;
        if (sts_i.ptr_end) begin
          cmd_o.wd_sel   = WD_ZERO;
          cmd_o.res_load = 1'b1;
          state_d        = S_DONE;
        end else begin
          cmd_o.wd_sel = WD_RDATA;
          if (sts_i.rd_zero) begin
            cmd_o.res_load = 1'b1;
            state_d        = S_DONE;
          end else begin
            cmd_o.ptr_op = PTR_INC;
          end
        end
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_clear_ends_at_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR && state_d != S_CLEAR) |-> sts_i.ptr_last)
    else $error("clear pass left before last slot");

  a_accept_to_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_LOOK)
    else $error("accepted word did not enter lookup");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result presented outside hand-off");

  a_zero_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOOK && sts_i.val_zero &&
     (sts_i.op == OP_SET || sts_i.op == OP_INSERT)) |-> !cmd_o.wr_en)
    else $error("zero value reached the store");
`endif

endmodule

`default_nettype wire
